// ===== rtl/core/scld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_pkg
// Shared types, character codes and hex decode helpers for the serial
// command line decoder.
// ----------------------------------------------------------------------------
package scld_pkg;

  localparam int CNT_W = 7;
  localparam int HDR_LEN = 15;
  localparam int DATA_START = 16;
  localparam int MAX_DATA = 62;

  localparam logic [7:0] CHR_LF = 8'h0A;
  localparam logic [7:0] CHR_US = 8'h5F;
  localparam logic [7:0] CHR_R  = 8'h52;
  localparam logic [7:0] CHR_C  = 8'h43;
  localparam logic [7:0] CHR_G  = 8'h47;
  localparam logic [7:0] CHR_SP = 8'h20;
  localparam logic [7:0] CHR_9  = 8'h39;
  localparam logic [7:0] CHR_0  = 8'h30;
  localparam logic [7:0] CHR_A  = 8'h41;

  typedef enum logic [2:0] {
    KIND_RELAY = 3'd0,
    KIND_CLEAR = 3'd1,
    KIND_GHDR  = 3'd2,
    KIND_GCHR  = 3'd3,
    KIND_ERR   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    LK_NONE,
    LK_RELAY,
    LK_CLEAR,
    LK_GFX,
    LK_ERR
  } line_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EMIT_ONE,
    S_GFX_READ,
    S_GFX_EMIT,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic  store;
    logic  clear;
    logic  ptr_init;
    logic  rd_issue;
    logic  pend_take;
    logic  out_load;
    kind_t out_kind;
    logic  out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic       is_lf;
    logic       at_last;
    line_kind_t line_kind;
    logic       pend_hdr;
    logic       look_zero;
    logic       out_free;
  } dp_sts_t;

  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c <= CHR_9) begin
      v = c - CHR_0;
    end else begin
      v = c - CHR_A + 8'd10;
    end
    return v;
  endfunction

  // second nibble is not masked to four bits
  function automatic logic [7:0] hex_pair(input logic [7:0] hi_c, input logic [7:0] lo_c);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = nibble_of(hi_c);
    lo = nibble_of(lo_c);
    return {hi[3:0], 4'h0} | lo;
  endfunction

endpackage

// ===== rtl/core/scld_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_ctrl
// Line decoder controller: takes bytes, walks the stored line at line end
// and sequences result requests into the datapath output register.
// ----------------------------------------------------------------------------
module scld_ctrl
  import scld_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && (sts.is_lf || sts.at_last)) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.line_kind)
          LK_NONE: state_nxt = S_CLEAR;
          LK_GFX:  state_nxt = S_GFX_READ;
          default: state_nxt = S_EMIT_ONE;
        endcase
      end
      S_EMIT_ONE: begin
        if (sts.out_free) begin
          state_nxt = S_CLEAR;
        end
      end
      S_GFX_READ: state_nxt = S_GFX_EMIT;
      S_GFX_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.look_zero ? S_CLEAR : S_GFX_READ;
        end
      end
      S_CLEAR: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.out_kind = KIND_ERR;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.store = in_valid && !sts.is_lf;
      end
      S_DECODE: begin
        cmd.ptr_init = (sts.line_kind == LK_GFX);
      end
      S_EMIT_ONE: begin
        cmd.out_load = sts.out_free;
        cmd.out_last = 1'b1;
        case (sts.line_kind)
          LK_RELAY: cmd.out_kind = KIND_RELAY;
          LK_CLEAR: cmd.out_kind = KIND_CLEAR;
          default:  cmd.out_kind = KIND_ERR;
        endcase
      end
      S_GFX_READ: begin
        cmd.rd_issue = 1'b1;
      end
      S_GFX_EMIT: begin
        cmd.out_load = sts.out_free;
        cmd.out_kind = sts.pend_hdr ? KIND_GHDR : KIND_GCHR;
        cmd.out_last = sts.look_zero;
        cmd.pend_take = sts.out_free && !sts.look_zero;
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/scld_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_dpath
// Line decoder datapath: line memory, header byte registers, fill count,
// data read pointer, hex field decode and the result output register.
// ----------------------------------------------------------------------------
module scld_dpath
  import scld_pkg::*;
#(
  parameter int LINE_LENGTH = 78
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_rx_byte,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_arg_a,
  output logic [7:0] out_arg_b,
  output logic [7:0] out_arg_c,
  output logic [7:0] out_arg_d,
  output logic [7:0] out_arg_e,
  output logic [7:0] out_arg_f,
  output logic [7:0] out_data_char,
  output logic       out_last
);

  localparam int AW = $clog2(LINE_LENGTH);
  localparam int DATA_END = (LINE_LENGTH < DATA_START + MAX_DATA) ?
                            LINE_LENGTH : DATA_START + MAX_DATA;

  logic [7:0]       mem [LINE_LENGTH];
  logic [7:0]       hdr_r [HDR_LEN];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] ptr_r;
  logic [7:0]       rd_q_r;
  logic             rd_ok_r;
  logic [7:0]       pend_char_r;
  logic             pend_hdr_r;

  logic             out_valid_r;
  logic             out_valid_nxt;
  kind_t            out_kind_r;
  logic [7:0]       arg_a_r, arg_b_r, arg_c_r, arg_d_r, arg_e_r, arg_f_r, char_r;
  logic [7:0]       arg_a_nxt, arg_b_nxt, arg_c_nxt, arg_d_nxt, arg_e_nxt, arg_f_nxt;
  logic [7:0]       char_nxt;
  logic             last_r;
  logic             out_free;

  logic [7:0] hex3, hex5, hex7, hex9, hex11, hex13;

  // line memory; reads at or above the fill count are treated as zero (look_zero)
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[count_r[AW-1:0]] <= in_rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_q_r <= mem[ptr_r[AW-1:0]];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.store) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < HDR_LEN; i++) begin
        hdr_r[i] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      if (cmd.clear) begin
        for (int i = 0; i < HDR_LEN; i++) begin
          hdr_r[i] <= '0;
        end
      end else if (cmd.store && (count_r < CNT_W'(HDR_LEN))) begin
        hdr_r[count_r[3:0]] <= in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      rd_ok_r    <= 1'b0;
      pend_hdr_r <= 1'b0;
    end else begin
      if (cmd.ptr_init) begin
        ptr_r      <= CNT_W'(DATA_START);
        pend_hdr_r <= 1'b1;
      end else if (cmd.pend_take) begin
        ptr_r      <= ptr_r + 1'b1;
        pend_hdr_r <= 1'b0;
      end
      if (cmd.rd_issue) begin
        rd_ok_r <= (ptr_r < count_r) && (ptr_r < CNT_W'(DATA_END));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_take) begin
      pend_char_r <= rd_q_r;
    end
  end

  assign hex3  = hex_pair(hdr_r[3], hdr_r[4]);
  assign hex5  = hex_pair(hdr_r[5], hdr_r[6]);
  assign hex7  = hex_pair(hdr_r[7], hdr_r[8]);
  assign hex9  = hex_pair(hdr_r[9], hdr_r[10]);
  assign hex11 = hex_pair(hdr_r[11], hdr_r[12]);
  assign hex13 = hex_pair(hdr_r[13], hdr_r[14]);

  always_comb begin
    sts.is_lf     = (in_rx_byte == CHR_LF);
    sts.at_last   = (count_r == CNT_W'(LINE_LENGTH - 1));
    sts.pend_hdr  = pend_hdr_r;
    sts.look_zero = !rd_ok_r || (rd_q_r == 8'h00);
    sts.out_free  = out_free;
    if (hdr_r[0] != CHR_US) begin
      sts.line_kind = LK_NONE;
    end else if (hdr_r[2] != CHR_SP) begin
      sts.line_kind = LK_ERR;
    end else if (hdr_r[1] == CHR_R) begin
      sts.line_kind = LK_RELAY;
    end else if (hdr_r[1] == CHR_C) begin
      sts.line_kind = LK_CLEAR;
    end else if (hdr_r[1] == CHR_G) begin
      sts.line_kind = LK_GFX;
    end else begin
      sts.line_kind = LK_ERR;
    end
  end

  // result output register
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    arg_a_nxt = '0;
    arg_b_nxt = '0;
    arg_c_nxt = '0;
    arg_d_nxt = '0;
    arg_e_nxt = '0;
    arg_f_nxt = '0;
    char_nxt  = '0;
    case (cmd.out_kind)
      KIND_RELAY: begin
        arg_a_nxt = hex3;
      end
      KIND_CLEAR: begin
        arg_a_nxt = hex3;
        arg_b_nxt = hex5;
        arg_c_nxt = hex7;
        arg_d_nxt = hex9;
        arg_e_nxt = hex11;
      end
      KIND_GHDR: begin
        arg_a_nxt = hex3;
        arg_b_nxt = hex5;
        arg_c_nxt = hex7;
        arg_d_nxt = hex9;
        arg_e_nxt = hex11;
        arg_f_nxt = hex13;
      end
      KIND_GCHR: begin
        char_nxt = pend_char_r;
      end
      default: begin
        char_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      arg_a_r    <= arg_a_nxt;
      arg_b_r    <= arg_b_nxt;
      arg_c_r    <= arg_c_nxt;
      arg_d_r    <= arg_d_nxt;
      arg_e_r    <= arg_e_nxt;
      arg_f_r    <= arg_f_nxt;
      char_r     <= char_nxt;
      last_r     <= cmd.out_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_arg_a     = arg_a_r;
  assign out_arg_b     = arg_b_r;
  assign out_arg_c     = arg_c_r;
  assign out_arg_d     = arg_d_r;
  assign out_arg_e     = arg_e_r;
  assign out_arg_f     = arg_f_r;
  assign out_data_char = char_r;
  assign out_last      = last_r;

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result loaded over a pending result");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LINE_LENGTH))
    else $error("fill count past line length");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (count_r == '0) && (hdr_r[0] == 8'h00))
    else $error("line not cleared");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_GCHR)) |-> (char_r != 8'h00))
    else $error("zero graphic data character emitted");

endmodule

// ===== rtl/core/serial_command_line_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_line_decoder_top
// Collects received bytes into a line and decodes relay, clear and graphic
// commands with hex arguments into result requests.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   in_      | in_valid / in_stall   | rx_byte
//   out_     | out_valid / out_stall | kind, arg_a..arg_f, data_char, last
//
// a byte that is not a line feed is stored while idle; in_stall is high outside idle
// line end (line feed or last entry filled): decode, then a relay, clear or error
// result, or none if the line does not start with '_'; graphic header and each data
// character: a read state, then a load; a clear state after the last result, then idle
// reset needs no clearing pass: reads at or past the fill count are treated as zero
// out_stall holds the result register; the controller waits on it
// ----------------------------------------------------------------------------
module serial_command_line_decoder_top
  import scld_pkg::*;
#(
  parameter int LINE_LENGTH = 78
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_arg_a,
  output logic [7:0] out_arg_b,
  output logic [7:0] out_arg_c,
  output logic [7:0] out_arg_d,
  output logic [7:0] out_arg_e,
  output logic [7:0] out_arg_f,
  output logic [7:0] out_data_char,
  output logic       out_last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  scld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  scld_dpath #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_rx_byte    (in_rx_byte),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_arg_a     (out_arg_a),
    .out_arg_b     (out_arg_b),
    .out_arg_c     (out_arg_c),
    .out_arg_d     (out_arg_d),
    .out_arg_e     (out_arg_e),
    .out_arg_f     (out_arg_f),
    .out_data_char (out_data_char),
    .out_last      (out_last)
  );

endmodule
